>>> src/dnsp_pkg.sv
// ----------------------------------------------------------------------------
// dnsp_pkg
// shared constants and types for the dns response a-record parser
// ----------------------------------------------------------------------------
package dnsp_pkg;

    // default packet length limit in bytes
    localparam int DEF_MAX_LEN = 512;

    // verdict codes
    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_ID_MISM   = 3'd2;
    localparam logic [2:0] ST_NOT_RESP  = 3'd3;
    localparam logic [2:0] ST_RCODE_ERR = 3'd4;
    localparam logic [2:0] ST_NO_ANS    = 3'd5;
    localparam logic [2:0] ST_MALFORMED = 3'd6;
    localparam logic [2:0] ST_NO_A      = 3'd7;

    typedef struct packed {
        logic [31:0] address;
        logic [3:0]  rcode;
        logic [2:0]  status;
    } t_result;

endpackage

>>> src/dnsp_core.sv
// ----------------------------------------------------------------------------
// dnsp_core
// byte-wise parse state of one dns response and its verdict on the last byte
// ----------------------------------------------------------------------------
module dnsp_core #(
    parameter int MAX_LEN = dnsp_pkg::DEF_MAX_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic [15:0]       i_txid,
    output dnsp_pkg::t_result o_result
);
    import dnsp_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN + 1);

    localparam logic [3:0] PH_HEADER  = 4'd0;
    localparam logic [3:0] PH_NAME    = 4'd1;
    localparam logic [3:0] PH_LABEL   = 4'd2;
    localparam logic [3:0] PH_PTR2    = 4'd3;
    localparam logic [3:0] PH_QFIXED  = 4'd4;
    localparam logic [3:0] PH_RRFIXED = 4'd5;
    localparam logic [3:0] PH_RDSKIP  = 4'd6;
    localparam logic [3:0] PH_RDADDR  = 4'd7;
    localparam logic [3:0] PH_DONE    = 4'd8;

    logic [IDX_W-1:0] r_idx,   n_idx;
    logic [3:0]       r_phase, n_phase;
    logic [15:0]      r_qleft, n_qleft;
    logic [15:0]      r_aleft, n_aleft;
    logic [15:0]      r_skip,  n_skip;
    logic [3:0]       r_foff,  n_foff;
    logic [15:0]      r_rtype, n_rtype;
    logic [15:0]      r_dlen,  n_dlen;
    logic [31:0]      r_addr,  n_addr;
    logic [2:0]       r_verd,  n_verd;
    logic [3:0]       r_rcode, n_rcode;

    always_comb begin
        n_idx   = r_idx;
        n_phase = r_phase;
        n_qleft = r_qleft;
        n_aleft = r_aleft;
        n_skip  = r_skip;
        n_foff  = r_foff;
        n_rtype = r_rtype;
        n_dlen  = r_dlen;
        n_addr  = r_addr;
        n_verd  = r_verd;
        n_rcode = r_rcode;
        o_result = '0;

        if (i_step) begin
            if (r_idx < IDX_W'(MAX_LEN)) begin
                if (r_phase == PH_HEADER) begin
                    case (r_idx)
                        IDX_W'(0): n_rtype = {i_byte, 8'h00};
                        IDX_W'(1): begin
                            n_rtype = {r_rtype[15:8], i_byte};
                            if ({r_rtype[15:8], i_byte} != i_txid) n_verd = ST_ID_MISM;
                        end
                        IDX_W'(2): begin
                            if (r_verd == ST_FOUND && !i_byte[7]) n_verd = ST_NOT_RESP;
                        end
                        IDX_W'(3): begin
                            if (r_verd == ST_FOUND) begin
                                n_rcode = i_byte[3:0];
                                if (i_byte[3:0] != 4'd0) n_verd = ST_RCODE_ERR;
                            end
                        end
                        IDX_W'(4): n_qleft = {i_byte, 8'h00};
                        IDX_W'(5): n_qleft = {r_qleft[15:8], i_byte};
                        IDX_W'(6): n_aleft = {i_byte, 8'h00};
                        IDX_W'(7): begin
                            n_aleft = {r_aleft[15:8], i_byte};
                            if (r_verd == ST_FOUND && {r_aleft[15:8], i_byte} == 16'd0)
                                n_verd = ST_NO_ANS;
                        end
                        IDX_W'(11): n_phase = (r_verd != ST_FOUND) ? PH_DONE : PH_NAME;
                        default: ;
                    endcase
                end else begin
                    case (r_phase)
                        PH_NAME, PH_PTR2: begin
                            if (r_phase == PH_NAME && i_byte != 8'd0) begin
                                if (i_byte[7:6] == 2'b11) begin
                                    n_phase = PH_PTR2;
                                end else begin
                                    n_skip  = {8'h00, i_byte};
                                    n_phase = PH_LABEL;
                                end
                            end else if (r_qleft != 16'd0) begin
                                // name ended: fixed part of a question
                                n_skip  = 16'd4;
                                n_phase = PH_QFIXED;
                            end else begin
                                n_foff  = 4'd0;
                                n_phase = PH_RRFIXED;
                            end
                        end
                        PH_LABEL: begin
                            n_skip = r_skip - 16'd1;
                            if (n_skip == 16'd0) n_phase = PH_NAME;
                        end
                        PH_QFIXED: begin
                            n_skip = r_skip - 16'd1;
                            if (n_skip == 16'd0) begin
                                n_qleft = r_qleft - 16'd1;
                                n_phase = PH_NAME;
                            end
                        end
                        PH_RRFIXED: begin
                            if (r_foff == 4'd0)      n_rtype = {i_byte, 8'h00};
                            else if (r_foff == 4'd1) n_rtype = {r_rtype[15:8], i_byte};
                            else if (r_foff == 4'd8) n_dlen  = {i_byte, 8'h00};
                            else if (r_foff == 4'd9) n_dlen  = {r_dlen[15:8], i_byte};
                            if (r_foff < 4'd9) begin
                                n_foff = r_foff + 4'd1;
                            end else if (n_rtype == 16'd1 && n_dlen == 16'd4) begin
                                n_foff  = 4'd0;
                                n_addr  = '0;
                                n_phase = PH_RDADDR;
                            end else if (n_dlen == 16'd0) begin
                                n_aleft = r_aleft - 16'd1;
                                if (n_aleft == 16'd0) begin
                                    n_verd  = ST_NO_A;
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase = PH_NAME;
                                end
                            end else begin
                                n_skip  = n_dlen;
                                n_phase = PH_RDSKIP;
                            end
                        end
                        PH_RDSKIP: begin
                            n_skip = r_skip - 16'd1;
                            if (n_skip == 16'd0) begin
                                n_aleft = r_aleft - 16'd1;
                                if (n_aleft == 16'd0) begin
                                    n_verd  = ST_NO_A;
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase = PH_NAME;
                                end
                            end
                        end
                        PH_RDADDR: begin
                            n_addr = {r_addr[23:0], i_byte};
                            n_foff = r_foff + 4'd1;
                            if (n_foff >= 4'd4) begin
                                n_verd  = ST_FOUND;
                                n_phase = PH_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
                n_idx = r_idx + IDX_W'(1);
            end

            if (i_last) begin
                if (n_phase == PH_HEADER) begin
                    o_result.status = ST_SHORT;
                end else if (n_phase == PH_DONE) begin
                    o_result.status = n_verd;
                    o_result.rcode  = (n_verd == ST_ID_MISM || n_verd == ST_NOT_RESP)
                                      ? 4'd0 : n_rcode;
                    o_result.address = (n_verd == ST_FOUND) ? n_addr : 32'd0;
                end else begin
                    o_result.status = ST_MALFORMED;
                    o_result.rcode  = n_rcode;
                end
                // back to reset values for the next packet
                n_idx   = '0;
                n_phase = PH_HEADER;
                n_qleft = '0;
                n_aleft = '0;
                n_skip  = '0;
                n_foff  = '0;
                n_rtype = '0;
                n_dlen  = '0;
                n_addr  = '0;
                n_verd  = ST_FOUND;
                n_rcode = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_phase <= PH_HEADER;
            r_qleft <= '0;
            r_aleft <= '0;
            r_skip  <= '0;
            r_foff  <= '0;
            r_rtype <= '0;
            r_dlen  <= '0;
            r_addr  <= '0;
            r_verd  <= ST_FOUND;
            r_rcode <= '0;
        end else begin
            r_idx   <= n_idx;
            r_phase <= n_phase;
            r_qleft <= n_qleft;
            r_aleft <= n_aleft;
            r_skip  <= n_skip;
            r_foff  <= n_foff;
            r_rtype <= n_rtype;
            r_dlen  <= n_dlen;
            r_addr  <= n_addr;
            r_verd  <= n_verd;
            r_rcode <= n_rcode;
        end
    end

endmodule

>>> src/dns_response_a_record_parser_top.sv
// ----------------------------------------------------------------------------
// dns_response_a_record_parser_top
// verdict path: last byte into the input register, verdict into the result register
// throughput: one byte per cycle; a last byte waits only while the previous
// verdict is still held, not taken
// reset: synchronous active-low; clears parse state, handshakes and txid to 0
// ----------------------------------------------------------------------------
module dns_response_a_record_parser_top #(
    parameter int MAX_LEN = dnsp_pkg::DEF_MAX_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // payload bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,   // last_byte
    // verdicts
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [2:0] status, [6:3] rcode, [38:7] address, [39] zero
    // expected transaction id
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import dnsp_pkg::*;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    // result register
    logic        r_out_valid;
    t_result     r_out;
    // configuration
    logic [15:0] r_txid;

    logic        s1_adv;
    t_result     core_res;

    // a non-last byte always moves on; a last byte needs room for its verdict
    assign s1_adv        = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || s1_adv;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_txid <= 16'd0;
        end else if (i_cfg_valid) begin
            r_txid <= i_cfg_data;
        end
    end

    dnsp_core #(
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_adv),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_txid   (r_txid),
        .o_result (core_res)
    );

    // result register, refilled in the cycle it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_in_last) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.address, r_out.rcode, r_out.status};

`ifndef NO_ASSERTIONS
    // a last byte stepped through the core always yields a verdict next cycle
    a_verdict_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_in_last) |=> m_axis_tvalid)
        else $error("verdict missing after last byte");

    // input stalls only behind a last byte waiting for the result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_in_last && r_out_valid))
        else $error("input stalled without a pending verdict");

    // an address is only reported with a found verdict
    a_addr_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.status != ST_FOUND) |-> (r_out.address == 32'd0))
        else $error("address on a failed verdict");

    // found implies a clean rcode
    a_found_rcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.status == ST_FOUND) |-> (r_out.rcode == 4'd0))
        else $error("nonzero rcode with found verdict");
`endif

endmodule

>>> sim/tb_dns_response_a_record_parser_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dns_response_a_record_parser_top
// self-checking bench for the dns a-record parser: dns responses, mostly
// well formed with random content plus truncated, corrupted and noise
// packets, are streamed in one byte per item. A behavioural parser in the
// bench predicts each verdict, and status, rcode and address are compared
// in order against what the block hands out
// ----------------------------------------------------------------------------
module tb_dns_response_a_record_parser_top;
    import dnsp_pkg::*;

    localparam int MAX_LEN      = DEF_MAX_LEN;
    localparam int ITEM_BUDGET  = 1650;     // payload items in the random part
    localparam int HOLD_CYCLES  = 400;      // long receiver back-pressure
    localparam int DRAIN_CYCLES = 6;        // idle margin once every verdict is back
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [15:0] RR_TYPE_A = 16'd1;

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] rx_byte
    logic        s_axis_tlast  = 1'b0;  // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // [2:0] status, [6:3] rcode, [38:7] address, [39] zero
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data    = '0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    dns_response_a_record_parser_top #(
        .MAX_LEN(MAX_LEN)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // behavioural parser: one call per accepted payload item
    // ------------------------------------------------------------------
    typedef enum logic [3:0] {
        PH_HEADER, PH_NAME, PH_LABEL, PH_PTR2, PH_QFIXED,
        PH_RRFIXED, PH_RDSKIP, PH_RDADDR, PH_DONE
    } t_parse_phase;

    logic [15:0]  txid_model = '0;      // follows every accepted register write
    t_parse_phase ph;
    int unsigned  pos;                  // bytes parsed so far, stops at MAX_LEN
    logic [15:0]  q_left, a_left, skip_left, rtype, rdlen;
    logic [3:0]   fofs, rc_seen;
    logic [31:0]  addr_acc;
    logic [2:0]   verdict;              // during the header zero means no failure yet
    t_result      verdicts_due[$];
    int           status_hits[8];

    task clear_parse();
        ph        = PH_HEADER;
        pos       = 0;
        q_left    = '0;
        a_left    = '0;
        skip_left = '0;
        rtype     = '0;
        rdlen     = '0;
        fofs      = '0;
        rc_seen   = '0;
        addr_acc  = '0;
        verdict   = ST_FOUND;
    endtask

    // a name is over: either question fixed fields or a resource record follow
    task enter_fixed();
        if (q_left != 0) begin
            skip_left = 16'd4;
            ph = PH_QFIXED;
        end else begin
            fofs = '0;
            ph = PH_RRFIXED;
        end
    endtask

    task end_record();
        a_left = a_left - 16'd1;
        if (a_left == 0) begin
            verdict = ST_NO_A;
            ph = PH_DONE;
        end else begin
            ph = PH_NAME;
        end
    endtask

    task parse_byte(input logic [7:0] b, input logic last);
        t_result v;
        // bytes past the length limit are dropped, but tlast still counts
        if (pos < MAX_LEN) begin
            if (ph == PH_HEADER) begin
                case (pos)
                    0: rtype = {b, 8'h00};
                    1: begin
                        rtype[7:0] = b;
                        if (rtype != txid_model) verdict = ST_ID_MISM;
                    end
                    2: if (verdict == ST_FOUND && !b[7]) verdict = ST_NOT_RESP;
                    3: if (verdict == ST_FOUND) begin
                        rc_seen = b[3:0];
                        if (rc_seen != 0) verdict = ST_RCODE_ERR;
                    end
                    4: q_left = {b, 8'h00};
                    5: q_left[7:0] = b;
                    6: a_left = {b, 8'h00};
                    7: begin
                        a_left[7:0] = b;
                        if (verdict == ST_FOUND && a_left == 0) verdict = ST_NO_ANS;
                    end
                    11: ph = (verdict != ST_FOUND) ? PH_DONE : PH_NAME;
                    default: ;
                endcase
            end else begin
                case (ph)
                    PH_NAME: begin
                        if (b == 8'h00) enter_fixed();
                        else if (b[7:6] == 2'b11) ph = PH_PTR2;   // compression pointer
                        else begin
                            skip_left = {8'h00, b};
                            ph = PH_LABEL;
                        end
                    end
                    PH_LABEL: begin
                        skip_left = skip_left - 16'd1;
                        if (skip_left == 0) ph = PH_NAME;
                    end
                    PH_PTR2: enter_fixed();
                    PH_QFIXED: begin
                        skip_left = skip_left - 16'd1;
                        if (skip_left == 0) begin
                            q_left = q_left - 16'd1;
                            ph = PH_NAME;
                        end
                    end
                    PH_RRFIXED: begin
                        case (fofs)
                            4'd0: rtype = {b, 8'h00};
                            4'd1: rtype[7:0] = b;
                            4'd8: rdlen = {b, 8'h00};
                            4'd9: rdlen[7:0] = b;
                            default: ;
                        endcase
                        if (fofs < 4'd9) begin
                            fofs = fofs + 4'd1;
                        end else if (rtype == RR_TYPE_A && rdlen == 16'd4) begin
                            fofs = '0;
                            addr_acc = '0;
                            ph = PH_RDADDR;
                        end else if (rdlen == 0) begin
                            end_record();
                        end else begin
                            skip_left = rdlen;
                            ph = PH_RDSKIP;
                        end
                    end
                    PH_RDSKIP: begin
                        skip_left = skip_left - 16'd1;
                        if (skip_left == 0) end_record();
                    end
                    PH_RDADDR: begin
                        addr_acc = {addr_acc[23:0], b};
                        fofs = fofs + 4'd1;
                        if (fofs >= 4'd4) begin
                            verdict = ST_FOUND;
                            ph = PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end
            pos++;
        end
        if (last) begin
            if (ph == PH_HEADER) begin
                v.status = ST_SHORT;
                v.rcode = '0;
                v.address = '0;
            end else if (ph == PH_DONE) begin
                v.status = verdict;
                v.rcode = (verdict == ST_ID_MISM || verdict == ST_NOT_RESP) ? 4'h0 : rc_seen;
                v.address = (verdict == ST_FOUND) ? addr_acc : 32'h0;
            end else begin
                // packet ran out before a verdict was reached
                v.status = ST_MALFORMED;
                v.rcode = rc_seen;
                v.address = '0;
            end
            verdicts_due.push_back(v);
            status_hits[v.status]++;
            clear_parse();
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: register writes, accepted payload items and verdict checks
    // ------------------------------------------------------------------
    int bytes_in     = 0;
    int verdicts_out = 0;
    int mismatches   = 0;

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) txid_model = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                bytes_in++;
                parse_byte(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[38:0]);
                verdicts_out++;
                if (verdicts_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: verdict: expected none, got status %0d rcode %0d address %h",
                             $time, got.status, got.rcode, got.address);
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.status !== want.status) begin
                        mismatches++;
                        $display("%0t: status: expected %0d, got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.rcode !== want.rcode) begin
                        mismatches++;
                        $display("%0t: rcode: expected %0d, got %0d",
                                 $time, want.rcode, got.rcode);
                    end
                    if (got.address !== want.address) begin
                        mismatches++;
                        $display("%0t: address: expected %h, got %h",
                                 $time, want.address, got.address);
                    end
                    if (m_axis_tdata[39] !== 1'b0) begin
                        mismatches++;
                        $display("%0t: tdata pad bit: expected 0, got %b",
                                 $time, m_axis_tdata[39]);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // payload driver: pops queued items, waits each item's gap first
    // ------------------------------------------------------------------
    typedef struct {
        logic [7:0] b;
        logic       last;
        int         gap;
    } t_pending_byte;

    t_pending_byte pending_items[$];
    bit            drv_busy       = 1'b0;
    bit            gap_loaded     = 1'b0;
    int            gap_left       = 0;
    int            bytes_launched = 0;

    always @(negedge i_clk) begin
        t_pending_byte nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            // the item on the bus has gone once the monitor has counted it
            if (drv_busy && bytes_in == bytes_launched) drv_busy = 1'b0;
            if (!drv_busy && pending_items.size() != 0) begin
                if (!gap_loaded) begin
                    gap_left = pending_items[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    nxt = pending_items.pop_front();
                    s_axis_tdata <= nxt.b;
                    s_axis_tlast <= nxt.last;
                    bytes_launched++;
                    drv_busy = 1'b1;
                    gap_loaded = 1'b0;
                end
            end
            // single assignment per step keeps tvalid high across back-to-back items
            s_axis_tvalid <= drv_busy;
        end
    end

    // ------------------------------------------------------------------
    // verdict receiver: random stall per item, plus one long hold-off
    // ------------------------------------------------------------------
    bit hold_kick = 1'b0;
    bit hold_ack  = 1'b0;
    int hold_left = 0;

    // hold-off counter in its own process, started by toggling hold_kick
    always @(posedge i_clk) begin
        if (hold_kick != hold_ack) begin
            hold_ack = hold_kick;
            hold_left = HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left--;
        end
    end

    int rx_seen  = 0;
    int rx_wait  = 0;
    bit rx_burst = 1'b0;

    always @(negedge i_clk) begin
        if (rx_seen != verdicts_out) begin
            rx_seen = verdicts_out;
            if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
            rx_wait = rx_burst ? 0 : $urandom_range(0, 13);
        end
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // run limit
    // ------------------------------------------------------------------
    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // packet building
    // ------------------------------------------------------------------
    logic [7:0] pkt[$];
    bit         tx_burst   = 1'b0;
    int         items_sent = 0;
    int         cfg_writes = 0;

    task put16(input logic [15:0] v);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endtask

    // labels of random length, now and then a huge one, ending in zero or a pointer
    task add_name();
        int len;
        repeat ($urandom_range(0, 3)) begin
            len = ($urandom_range(0, 59) == 0) ? $urandom_range(8'h40, 8'hBF)
                                               : $urandom_range(1, 6);
            pkt.push_back(8'(len));
            repeat (len) pkt.push_back(8'($urandom));
        end
        if ($urandom_range(0, 2) == 0) begin
            pkt.push_back({2'b11, 6'($urandom)});
            pkt.push_back(8'($urandom));
        end else begin
            pkt.push_back(8'h00);
        end
    endtask

    task make_response(input logic [15:0] id);
        int          qd, an, rr_count, cut;
        logic [15:0] rr_type, rd_len;
        pkt.delete();
        put16(($urandom_range(0, 11) == 0) ? 16'($urandom) : id);
        pkt.push_back({($urandom_range(0, 11) != 0), 7'($urandom)});
        pkt.push_back({4'($urandom), ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'h0});
        qd = $urandom_range(0, 2);
        case ($urandom_range(0, 19))
            0:       an = 0;
            1:       an = 16'($urandom);     // claims more records than are sent
            default: an = $urandom_range(1, 3);
        endcase
        rr_count = (an > 3) ? 3 : an;
        put16(16'(qd));
        put16(16'(an));
        put16(16'($urandom));               // authority and additional counts, unused
        put16(16'($urandom));
        repeat (qd) begin
            add_name();
            repeat (4) pkt.push_back(8'($urandom));
        end
        repeat (rr_count) begin
            add_name();
            rr_type = ($urandom_range(0, 1) == 0) ? RR_TYPE_A : 16'($urandom);
            rd_len = (rr_type == RR_TYPE_A && $urandom_range(0, 3) != 0) ? 16'd4
                                                                        : 16'($urandom_range(0, 6));
            put16(rr_type);
            put16(16'($urandom));           // class
            put16(16'($urandom));           // ttl
            put16(16'($urandom));
            put16(rd_len);
            repeat (rd_len) pkt.push_back(8'($urandom));
        end
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
        // broken packets: cut anywhere, or plain noise
        if ($urandom_range(0, 6) == 0) begin
            cut = $urandom_range(1, pkt.size());
            while (pkt.size() > cut) void'(pkt.pop_back());
        end else if ($urandom_range(0, 19) == 0) begin
            pkt.delete();
            repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
        end
    endtask

    task send_packet();
        t_pending_byte it;
        if ($urandom_range(0, 5) == 0) tx_burst = !tx_burst;
        foreach (pkt[k]) begin
            it.b = pkt[k];
            it.last = (k == pkt.size() - 1);
            it.gap = tx_burst ? 0 : $urandom_range(0, 13);
            pending_items.push_back(it);
            if (k < MAX_LEN) items_sent++;
        end
    endtask

    // sender pause: nothing queued, nothing on the bus, every verdict back
    task wait_idle();
        while (pending_items.size() != 0 || drv_busy || verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task write_txid(input logic [15:0] id);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= id;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        logic [15:0] txid_plan[4];
        int          phase_end;
        clear_parse();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short packet, then two headers where several checks fail
        // at once so that only the earliest one may be reported
        write_txid(16'h0000);
        pkt = {8'hFF};
        send_packet();
        pkt = {8'hFF, 8'hFF, 8'h00, 8'h0F, 8'h00, 8'h00,
               8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_packet();
        pkt = {8'h00, 8'h00, 8'h7F, 8'hF3, 8'h00, 8'h01,
               8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_packet();
        wait_idle();

        txid_plan = '{16'h0000, 16'hFFFF, 16'($urandom), 16'h8001};
        foreach (txid_plan[p]) begin
            if (p != 0) begin
                wait_idle();
                write_txid(txid_plan[p]);
            end
            if (p == 1) begin
                // receiver holds off while short packets keep coming, so the
                // verdict path backs up and the payload input has to stall
                @(negedge i_clk);
                hold_kick = !hold_kick;
                repeat (25) begin
                    pkt.delete();
                    repeat ($urandom_range(1, 11)) pkt.push_back(8'($urandom));
                    send_packet();
                end
                wait_idle();
                // one packet longer than the limit: the a record lies beyond
                // it, so the parse is still inside a skipped record at the end
                pkt.delete();
                put16(txid_plan[p]);
                pkt.push_back(8'h81);
                pkt.push_back(8'h80);
                put16(16'd0);
                put16(16'd2);
                put16(16'd0);
                put16(16'd0);
                pkt.push_back(8'h00);
                put16(16'h0010);
                put16(16'd1);
                put16(16'($urandom));
                put16(16'($urandom));
                put16(16'd520);
                repeat (520) pkt.push_back(8'($urandom));
                pkt.push_back(8'hC0);
                pkt.push_back(8'h0C);
                put16(RR_TYPE_A);
                put16(16'd1);
                put16(16'($urandom));
                put16(16'($urandom));
                put16(16'd4);
                repeat (4) pkt.push_back(8'($urandom));
                send_packet();
            end
            phase_end = 25 + (p + 1) * ITEM_BUDGET / 4;
            while (items_sent < phase_end) begin
                make_response(txid_plan[p]);
                send_packet();
            end
        end

        wait_idle();
        $display("run covered %0d payload items, %0d verdicts, %0d txid writes",
                 items_sent, verdicts_out, cfg_writes);
        $display({"verdicts by status: found %0d short %0d id %0d qr %0d",
                  " rcode %0d none %0d bad %0d no-a %0d"},
                 status_hits[ST_FOUND], status_hits[ST_SHORT], status_hits[ST_ID_MISM],
                 status_hits[ST_NOT_RESP], status_hits[ST_RCODE_ERR], status_hits[ST_NO_ANS],
                 status_hits[ST_MALFORMED], status_hits[ST_NO_A]);
        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
